// ----- design/pmis_pkg.sv -----
// Package: shared widths, constants and types of the pattern match index sum block.
`default_nettype none
package pmis_pkg;

   // Character and result widths
   localparam int SYM_W = 8;
   localparam int SUM_W = 21;
   localparam logic [SUM_W-1:0] SUM_MAX = 21'h1FFFFF;

   // Mode register codes
   localparam logic MODE_SUBSTRING   = 1'b0;
   localparam logic MODE_SUBSEQUENCE = 1'b1;

   // Command codes of an input transaction
   localparam logic CMD_PATTERN = 1'b0;
   localparam logic CMD_TEXT    = 1'b1;

   // Sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_RUN = 3'b001,
      ST_MUL = 3'b010,
      ST_ADD = 3'b100
   } fsm_type;

   // Control broadcast to every cell of the compare chain
   typedef struct packed {
      logic             shift;
      logic             flush;
      logic [SYM_W-1:0] symbol;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ----- design/pmis_req_if.sv -----
// Interface: request channel carrying pattern and text characters.
`default_nettype none
interface pmis_req_if;
   logic                       valid;
   logic                       ready;
   logic                       cmd;
   logic [pmis_pkg::SYM_W-1:0] symbol;
   logic                       last;

   modport source (output valid, output cmd, output symbol, output last, input ready);
   modport sink   (input valid, input cmd, input symbol, input last, output ready);
endinterface
`default_nettype wire

// ----- design/pmis_rsp_if.sv -----
// Interface: response channel carrying the index sum and overflow flag.
`default_nettype none
interface pmis_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [pmis_pkg::SUM_W-1:0] index_sum;
   logic                       overflow;

   modport source (output valid, output index_sum, output overflow, input ready);
   modport sink   (input valid, input index_sum, input overflow, output ready);
endinterface
`default_nettype wire

// ----- design/pattern_match_index_sum.sv -----
// Top level: pattern load, systolic substring compare chain and greedy subsequence sum.
// Throughput: one pattern or text transaction per cycle; after a text transaction marked
//   last, ready stays low in ST_MUL, and in ST_ADD until the response slot is free.
// Finish: after the last text transaction is taken, the multiply stage registers the
//   product and triangular term, then the add/saturate loads the response register.
// Reset: synchronous, clears control and text sums; pattern and result data are kept.
`default_nettype none
module pattern_match_index_sum #(
   parameter int PATTERN_MAX = 16,
   parameter int TEXT_MAX    = 65536
) (
   input  wire               clock,
   input  wire               reset,
   pmis_req_if.sink          req_chan,
   pmis_rsp_if.source        rsp_chan,
   input  wire               csr_we,
   input  wire               csr_wdata
);

   localparam int CNT_W  = $clog2(PATTERN_MAX + 1);
   localparam int PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int IDX_W  = $clog2(TEXT_MAX + 1);
   localparam int PROD_W = CNT_W + IDX_W;
   localparam int TRI_W  = 2 * CNT_W;
   localparam int TOT_W  = PROD_W + TRI_W;
   localparam int CMP_W  = (TOT_W > pmis_pkg::SUM_W) ? TOT_W : pmis_pkg::SUM_W;
   localparam int RUNX_W = pmis_pkg::SUM_W + 1;

   // Control and accumulator registers
   pmis_pkg::fsm_type          state_ff, state_in;
   logic                       mode_ff;
   logic [CNT_W-1:0]           pat_cnt_ff, pat_cnt_in;
   logic                       text_phase_ff, text_phase_in;
   logic [IDX_W-1:0]           text_idx_ff, text_idx_in;
   logic [CNT_W-1:0]           subpos_ff, subpos_in;
   logic [pmis_pkg::SUM_W-1:0] run_sum_ff, run_sum_in;
   logic                       found_ff, found_in;
   logic [IDX_W-1:0]           start_ff, start_in;
   logic                       ovf_ff, ovf_in;

   // Finishing pipeline registers
   logic                       fin_mode_ff, fin_found_ff, fin_ovf_ff;
   logic [IDX_W-1:0]           fin_start_ff;
   logic [CNT_W-1:0]           fin_m_ff;
   logic [pmis_pkg::SUM_W-1:0] fin_run_ff;
   logic [PROD_W-1:0]          prod_ff;
   logic [TRI_W-1:0]           tri_ff;

   // Response register
   logic                       rsp_valid_ff;
   logic [pmis_pkg::SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic                       rsp_ovf_ff;

   // Handshake decode
   logic req_fire, is_pat, is_text, is_last, new_job, in_range, take, clear_text;
   logic out_free, load_rsp;
   logic [CNT_W-1:0] eff_cnt, m_minus1;
   logic pat_room;

   // Chain signals
   pmis_pkg::cell_ctrl_type    cell_ctrl;
   logic [PATTERN_MAX-1:0]     match_nxt, match_q, load_vec;
   logic [pmis_pkg::SYM_W-1:0] pat_vec [PATTERN_MAX];

   // Search results of this transaction
   logic                       hit_now, sub_hit;
   logic [IDX_W-1:0]           start_now;
   logic [RUNX_W-1:0]          run_add;
   logic [pmis_pkg::SUM_W-1:0] run_sat;
   logic [CMP_W-1:0]           total;
   logic [pmis_pkg::SUM_W-1:0] sub_sat;

   assign req_fire   = req_chan.valid & req_chan.ready;
   assign is_pat     = req_fire & (req_chan.cmd == pmis_pkg::CMD_PATTERN);
   assign is_text    = req_fire & (req_chan.cmd == pmis_pkg::CMD_TEXT);
   assign is_last    = is_text & req_chan.last;
   assign new_job    = is_pat & text_phase_ff;
   assign in_range   = text_idx_ff < IDX_W'(TEXT_MAX);
   assign take       = is_text & in_range;
   assign clear_text = is_last | new_job;
   assign eff_cnt    = new_job ? '0 : pat_cnt_ff;
   assign pat_room   = eff_cnt < CNT_W'(PATTERN_MAX);
   assign m_minus1   = pat_cnt_ff - CNT_W'(1);

   assign req_chan.ready = (state_ff == pmis_pkg::ST_RUN);

   // Broadcast to the chain
   assign cell_ctrl.shift  = take;
   assign cell_ctrl.flush  = clear_text;
   assign cell_ctrl.symbol = req_chan.symbol;

   // Row of compare cells, cell k matches pattern character k
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic match_left;
      if (k == 0) begin : g_head
         assign match_left = 1'b1;
      end else begin : g_body
         assign match_left = match_q[k-1];
      end
      assign load_vec[k] = is_pat & pat_room & (eff_cnt == CNT_W'(k));
      pmis_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .load_en   (load_vec[k]),
         .match_in  (match_left),
         .match_nxt (match_nxt[k]),
         .match_ff  (match_q[k]),
         .pat_ff    (pat_vec[k])
      );
   end

   // Substring hit: whole pattern ends at this character
   assign hit_now   = take & ~found_ff & (pat_cnt_ff != '0) & match_nxt[m_minus1[PIDX_W-1:0]];
   assign start_now = text_idx_ff + IDX_W'(1) - IDX_W'(pat_cnt_ff);

   // Greedy subsequence step
   assign sub_hit = take & (subpos_ff < pat_cnt_ff)
                  & (pat_vec[subpos_ff[PIDX_W-1:0]] == req_chan.symbol);
   assign run_add = RUNX_W'(run_sum_ff) + RUNX_W'(text_idx_ff);
   assign run_sat = (run_add > RUNX_W'(pmis_pkg::SUM_MAX)) ? pmis_pkg::SUM_MAX
                                                           : run_add[pmis_pkg::SUM_W-1:0];

   // Next values of the text state
   always_comb begin
      pat_cnt_in    = pat_cnt_ff;
      text_phase_in = text_phase_ff;
      text_idx_in   = take ? text_idx_ff + IDX_W'(1) : text_idx_ff;
      subpos_in     = sub_hit ? subpos_ff + CNT_W'(1) : subpos_ff;
      run_sum_in    = sub_hit ? run_sat : run_sum_ff;
      found_in      = found_ff | hit_now;
      start_in      = hit_now ? start_now : start_ff;
      ovf_in        = ovf_ff | (is_text & ~in_range);
      if (is_pat) begin
         text_phase_in = 1'b0;
         pat_cnt_in    = pat_room ? eff_cnt + CNT_W'(1) : eff_cnt;
      end
      if (is_text) begin
         text_phase_in = 1'b1;
      end
   end

   // Text state, cleared after the last character and at a new job
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= pmis_pkg::MODE_SUBSTRING;
         pat_cnt_ff    <= '0;
         text_phase_ff <= 1'b0;
         text_idx_ff   <= '0;
         subpos_ff     <= '0;
         run_sum_ff    <= '0;
         found_ff      <= 1'b0;
         start_ff      <= '0;
         ovf_ff        <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         pat_cnt_ff    <= pat_cnt_in;
         text_phase_ff <= text_phase_in;
         if (clear_text) begin
            text_idx_ff <= '0;
            subpos_ff   <= '0;
            run_sum_ff  <= '0;
            found_ff    <= 1'b0;
            start_ff    <= '0;
            ovf_ff      <= 1'b0;
         end else begin
            text_idx_ff <= text_idx_in;
            subpos_ff   <= subpos_in;
            run_sum_ff  <= run_sum_in;
            found_ff    <= found_in;
            start_ff    <= start_in;
            ovf_ff      <= ovf_in;
         end
      end
   end

   // Capture the finished text for the finishing pipeline
   always_ff @(posedge clock) begin
      if (is_last) begin
         fin_mode_ff  <= mode_ff;
         fin_found_ff <= found_in;
         fin_start_ff <= start_in;
         fin_m_ff     <= pat_cnt_ff;
         fin_run_ff   <= run_sum_in;
         fin_ovf_ff   <= ovf_in;
      end
   end

   // Multiply stage: m*start and the triangular term
   always_ff @(posedge clock) begin
      if (state_ff == pmis_pkg::ST_MUL) begin
         prod_ff <= PROD_W'(fin_m_ff) * PROD_W'(fin_start_ff);
         tri_ff  <= (TRI_W'(fin_m_ff) * (TRI_W'(fin_m_ff) - TRI_W'(1))) >> 1;
      end
   end

   // Add stage: sum, saturate and select by mode
   assign total   = CMP_W'(prod_ff) + CMP_W'(tri_ff);
   assign sub_sat = (total > CMP_W'(pmis_pkg::SUM_MAX)) ? pmis_pkg::SUM_MAX
                                                        : total[pmis_pkg::SUM_W-1:0];
   always_comb begin
      if (fin_mode_ff == pmis_pkg::MODE_SUBSEQUENCE) begin
         rsp_sum_in = fin_run_ff;
      end else if (fin_found_ff) begin
         rsp_sum_in = sub_sat;
      end else begin
         rsp_sum_in = '0;
      end
   end

   assign out_free = ~rsp_valid_ff | rsp_chan.ready;
   assign load_rsp = (state_ff == pmis_pkg::ST_ADD) & out_free;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pmis_pkg::ST_RUN: begin
            if (is_last) begin
               state_in = pmis_pkg::ST_MUL;
            end
         end
         pmis_pkg::ST_MUL: begin
            state_in = pmis_pkg::ST_ADD;
         end
         pmis_pkg::ST_ADD: begin
            if (out_free) begin
               state_in = pmis_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = pmis_pkg::ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pmis_pkg::ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the response payload until taken
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_sum_ff <= rsp_sum_in;
         rsp_ovf_ff <= fin_ovf_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.index_sum = rsp_sum_ff;
   assign rsp_chan.overflow  = rsp_ovf_ff;

endmodule
`default_nettype wire

// ----- design/pmis_cell.sv -----
// Compare cell: holds one pattern character and the partial-match flag ending at it.
`default_nettype none
module pmis_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  wire pmis_pkg::cell_ctrl_type ctrl,
   input  wire                          load_en,
   input  wire                          match_in,
   output logic                         match_nxt,
   output logic                         match_ff,
   output logic [pmis_pkg::SYM_W-1:0]   pat_ff
);

   logic match_in_q;

   // Extend the neighbour's match by one character
   assign match_nxt  = match_in & (pat_ff == ctrl.symbol);
   assign match_in_q = ctrl.flush ? 1'b0 : (ctrl.shift ? match_nxt : match_ff);

   // Hold the pattern character once loaded
   always_ff @(posedge clock) begin
      if (load_en) begin
         pat_ff <= ctrl.symbol;
      end
   end

   // Advance the match flag on each text character, drop it on flush
   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in_q;
      end
   end

endmodule
`default_nettype wire

// ----- design/pmis_checker.sv -----
// Checker: port-level properties of the pattern match index sum block, bound to the top.
`default_nettype none
module pmis_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         req_valid,
   input wire                         req_ready,
   input wire                         req_cmd,
   input wire                         req_last,
   input wire                         rsp_valid,
   input wire                         rsp_ready,
   input wire [pmis_pkg::SUM_W-1:0]   rsp_index_sum,
   input wire                         rsp_overflow
);

   logic last_fire;
   assign last_fire = req_valid & req_ready & (req_cmd == pmis_pkg::CMD_TEXT) & req_last;

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index_sum) && $stable(rsp_overflow))
      else $error("response changed while stalled");

   // The request side pauses after a last text transaction
   a_pause_after_last: assert property (@(posedge clock) disable iff (reset)
      last_fire |=> !req_ready)
      else $error("request accepted right after last text transaction");

   // Ready only drops because a last text transaction was taken
   a_ready_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(last_fire))
      else $error("request ready fell without a last text transaction");

   // A fresh response follows a last text transaction by a fixed delay
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(last_fire, 3))
      else $error("response without matching last text transaction");

endmodule

bind pattern_match_index_sum pmis_checker u_pmis_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_cmd       (req_chan.cmd),
   .req_last      (req_chan.last),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_index_sum (rsp_chan.index_sum),
   .rsp_overflow  (rsp_chan.overflow)
);
`default_nettype wire
